FILE: rtl/fbpa_pkg.sv
// Shared types, widths and codes for the fixed block pool allocator.
package fbpa_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 1024;

    localparam int INDEX_W    = 10;
    localparam int SIZE_W     = 16;
    localparam int ALIGN_W    = 13;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 11;
    localparam int BYTES_W    = 26;
    localparam int STRIDE_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]   CNT_MAX          = '1;
    localparam logic [BYTES_W-1:0] BYTES_SAT        = '1;
    localparam logic [ADDR_W-1:0]  RST_BASE         = 32'd0;
    localparam logic [SIZE_W-1:0]  RST_BLOCK_BYTES  = 16'd64;
    localparam logic [ALIGN_W-1:0] RST_ALIGN_BYTES  = 13'd0;
    localparam logic [CNT_W-1:0]   RST_BLOCKS       = 11'd1024;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_RESIZE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_RESIZE   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE          = 2'd0,
        CFG_BLOCK_BYTES   = 2'd1,
        CFG_ALIGN_BYTES   = 2'd2,
        CFG_BLOCKS_IN_USE = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_status           status;
        logic              grant;
        logic [CNT_W-1:0]  index;
        logic [CNT_W-1:0]  used;
    } t_step;

endpackage

FILE: rtl/fbpa_core.sv
// Free list control: link memory, list head, watermark and block count.
module fbpa_core #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [1:0]                    i_op,
    input  logic [fbpa_pkg::INDEX_W-1:0]  i_block_index,
    input  logic [fbpa_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [fbpa_pkg::ALIGN_W-1:0]  i_request_align,
    input  logic [fbpa_pkg::SIZE_W-1:0]   i_block_bytes,
    input  logic [fbpa_pkg::ALIGN_W-1:0]  i_align_bytes,
    input  logic [fbpa_pkg::CNT_W-1:0]    i_pool_blocks,
    output logic                          o_step_valid,
    input  logic                          i_step_ready,
    output fbpa_pkg::t_step               o_step
);

    localparam int LINK_DEPTH = (MAX_BLOCKS < (1 << fbpa_pkg::INDEX_W)) ?
                                MAX_BLOCKS : (1 << fbpa_pkg::INDEX_W);
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int LINK_W     = $clog2(LINK_DEPTH + 1);
    localparam int CNT_W      = fbpa_pkg::CNT_W;

    fbpa_pkg::t_state                 r_state, n_state;
    fbpa_pkg::t_op                    r_op;
    logic [fbpa_pkg::INDEX_W-1:0]     r_idx;
    logic [fbpa_pkg::SIZE_W-1:0]      r_size;
    logic [fbpa_pkg::ALIGN_W-1:0]     r_align;
    logic [LINK_W-1:0]                r_rdata;
    logic [LINK_W-1:0]                r_head, n_head;
    logic [CNT_W-1:0]                 r_fresh, n_fresh;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic [LINK_W-1:0]                mem_link [LINK_DEPTH];

    logic                             req_fire;
    logic                             commit;
    logic                             wr_en;
    logic                             free_ok;
    logic                             mismatch;
    logic [LINK_W-1:0]                head_m1;
    logic [LINK_AW-1:0]               rd_addr;
    logic [LINK_AW-1:0]               wr_addr;
    fbpa_pkg::t_step                  step;

    assign req_fire = i_req_valid && o_req_ready;
    assign commit   = o_step_valid && i_step_ready;
    assign head_m1  = r_head - LINK_W'(1);
    assign rd_addr  = head_m1[LINK_AW-1:0];
    assign wr_addr  = r_idx[LINK_AW-1:0];
    assign free_ok  = ({1'b0, r_idx} < i_pool_blocks);
    assign mismatch = (r_size != i_block_bytes) || (r_align != i_align_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_step_valid = 1'b0;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = fbpa_pkg::S_EXEC;
                end
            end
            fbpa_pkg::S_EXEC: begin
                o_step_valid = 1'b1;
                if (i_step_ready) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_fresh     = r_fresh;
        n_count     = r_count;
        wr_en       = 1'b0;
        step.status = fbpa_pkg::ST_OK;
        step.grant  = 1'b0;
        step.index  = '0;
        unique case (r_op)
            fbpa_pkg::OP_ALLOC: begin
                priority if (mismatch) begin
                    step.status = fbpa_pkg::ST_MISMATCH;
                end else if (r_head != '0) begin
                    step.grant = 1'b1;
                    step.index = CNT_W'(head_m1);
                    n_head     = r_rdata;
                end else if (r_fresh < i_pool_blocks) begin
                    step.grant = 1'b1;
                    step.index = r_fresh;
                    n_fresh    = r_fresh + CNT_W'(1);
                end else begin
                    step.status = fbpa_pkg::ST_EMPTY;
                end
                if (step.grant && (r_count != fbpa_pkg::CNT_MAX)) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            fbpa_pkg::OP_FREE: begin
                if (free_ok) begin
                    wr_en  = 1'b1;
                    n_head = LINK_W'(r_idx) + LINK_W'(1);
                    if (r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            fbpa_pkg::OP_FREE_ALL: begin
                n_head  = '0;
                n_fresh = '0;
                n_count = '0;
            end
            fbpa_pkg::OP_RESIZE: begin
                step.status = fbpa_pkg::ST_RESIZE;
            end
        endcase
        step.used = n_count;
    end

    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fresh <= '0;
            r_count <= '0;
        end else if (commit) begin
            r_head  <= n_head;
            r_fresh <= n_fresh;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op    <= fbpa_pkg::t_op'(i_op);
            r_idx   <= i_block_index;
            r_size  <= i_request_size;
            r_align <= i_request_align;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rdata <= mem_link[rd_addr];
        end
        if (commit && wr_en) begin
            mem_link[wr_addr] <= r_head;
        end
    end

    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step_valid && !i_step_ready |=> o_step_valid && $stable(o_step))
        else $error("step changed while stalled");

    a_free_all_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && (r_op == fbpa_pkg::OP_FREE_ALL)
        |=> (r_head == '0) && (r_fresh == '0) && (r_count == '0))
        else $error("free all left state behind");

    a_free_links: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && (r_op == fbpa_pkg::OP_FREE) && free_ok |=> r_head != '0)
        else $error("free did not set list head");

    a_grant_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && o_step.grant |=> r_count != '0)
        else $error("grant left block count at zero");

endmodule

FILE: rtl/fbpa_result.sv
// Result path: address and byte count products, saturation and output register.
module fbpa_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step_valid,
    output logic                          o_step_ready,
    input  fbpa_pkg::t_step               i_step,
    input  logic [fbpa_pkg::ADDR_W-1:0]   i_base,
    input  logic [fbpa_pkg::SIZE_W-1:0]   i_block_bytes,
    input  logic [fbpa_pkg::ALIGN_W-1:0]  i_align_bytes,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic [1:0]                    o_status,
    output logic [fbpa_pkg::INDEX_W-1:0]  o_granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]    o_used_blocks,
    output logic [fbpa_pkg::BYTES_W-1:0]  o_used_bytes
);

    localparam int PA_W = fbpa_pkg::CNT_W + fbpa_pkg::STRIDE_W;
    localparam int PB_W = fbpa_pkg::CNT_W + fbpa_pkg::SIZE_W;

    logic                              r_s1_valid;
    fbpa_pkg::t_step                   r_s1_step;
    logic [PA_W-1:0]                   r_s1_addr_prod;
    logic [PB_W-1:0]                   r_s1_bytes_prod;
    logic                              r_out_valid;
    fbpa_pkg::t_status                 r_out_status;
    logic [fbpa_pkg::INDEX_W-1:0]      r_out_index;
    logic [fbpa_pkg::ADDR_W-1:0]       r_out_addr;
    logic [fbpa_pkg::CNT_W-1:0]        r_out_used;
    logic [fbpa_pkg::BYTES_W-1:0]      r_out_bytes;

    logic [fbpa_pkg::STRIDE_W-1:0]     stride;
    logic [PA_W-1:0]                   addr_prod;
    logic [PB_W-1:0]                   bytes_prod;
    logic                              out_move;
    logic                              s1_fire;
    logic [fbpa_pkg::ADDR_W-1:0]       n_addr;
    logic [fbpa_pkg::BYTES_W-1:0]      n_bytes;

    assign stride       = fbpa_pkg::STRIDE_W'(i_block_bytes)
                        + fbpa_pkg::STRIDE_W'(i_align_bytes);
    assign addr_prod    = PA_W'(i_step.index) * PA_W'(stride);
    assign bytes_prod   = PB_W'(i_step.used) * PB_W'(i_block_bytes);
    assign out_move     = !r_out_valid || i_rsp_ready;
    assign o_step_ready = !r_s1_valid || out_move;
    assign s1_fire      = i_step_valid && o_step_ready;

    assign n_addr  = r_s1_step.grant ?
                     (i_base + fbpa_pkg::ADDR_W'(r_s1_addr_prod)) : '0;
    assign n_bytes = (|r_s1_bytes_prod[PB_W-1:fbpa_pkg::BYTES_W]) ?
                     fbpa_pkg::BYTES_SAT : r_s1_bytes_prod[fbpa_pkg::BYTES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_step_ready) begin
                r_s1_valid <= i_step_valid;
            end
            if (out_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s1_step       <= i_step;
            r_s1_addr_prod  <= addr_prod;
            r_s1_bytes_prod <= bytes_prod;
        end
        if (out_move && r_s1_valid) begin
            r_out_status <= r_s1_step.status;
            r_out_index  <= r_s1_step.index[fbpa_pkg::INDEX_W-1:0];
            r_out_addr   <= n_addr;
            r_out_used   <= r_s1_step.used;
            r_out_bytes  <= n_bytes;
        end
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_index   = r_out_index;
    assign o_granted_address = r_out_addr;
    assign o_used_blocks     = r_out_used;
    assign o_used_bytes      = r_out_bytes;

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != fbpa_pkg::ST_OK)
        |-> (r_out_addr == '0) && (r_out_index == '0))
        else $error("failed request carries a grant");

    a_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_used == '0) |-> r_out_bytes == '0)
        else $error("used bytes nonzero with no blocks");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_rsp_ready |=> r_out_valid)
        else $error("pending response dropped");

endmodule

FILE: rtl/fixed_block_pool_allocator.sv
// In the control path, the accept state reads the link memory at the list head, and the execute
// state updates head, watermark and count and hands the step on once it is taken, so a new
// request is accepted only after the step of the last one has been handed on. A response
// follows the step through a multiply stage and the output register, which
// lets the next request enter while a response waits. There is no clearing pass after reset.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [1:0]                       i_op,
    input  logic [fbpa_pkg::INDEX_W-1:0]     i_block_index,
    input  logic [fbpa_pkg::SIZE_W-1:0]      i_request_size,
    input  logic [fbpa_pkg::ALIGN_W-1:0]     i_request_align,
    output logic                             o_rsp_valid,
    input  logic                             i_rsp_ready,
    output logic [1:0]                       o_status,
    output logic [fbpa_pkg::INDEX_W-1:0]     o_granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]      o_granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]       o_used_blocks,
    output logic [fbpa_pkg::BYTES_W-1:0]     o_used_bytes
);

    logic [fbpa_pkg::ADDR_W-1:0]   r_base;
    logic [fbpa_pkg::SIZE_W-1:0]   r_block_bytes;
    logic [fbpa_pkg::ALIGN_W-1:0]  r_align_bytes;
    logic [fbpa_pkg::CNT_W-1:0]    r_blocks_in_use;
    logic [fbpa_pkg::CNT_W-1:0]    pool_blocks;
    logic                          step_valid;
    logic                          step_ready;
    fbpa_pkg::t_step               step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base          <= fbpa_pkg::RST_BASE;
            r_block_bytes   <= fbpa_pkg::RST_BLOCK_BYTES;
            r_align_bytes   <= fbpa_pkg::RST_ALIGN_BYTES;
            r_blocks_in_use <= fbpa_pkg::RST_BLOCKS;
        end else if (i_cfg_we) begin
            unique case (fbpa_pkg::t_cfg_reg'(i_cfg_index))
                fbpa_pkg::CFG_BASE: begin
                    r_base <= i_cfg_wdata[fbpa_pkg::ADDR_W-1:0];
                end
                fbpa_pkg::CFG_BLOCK_BYTES: begin
                    r_block_bytes <= i_cfg_wdata[fbpa_pkg::SIZE_W-1:0];
                end
                fbpa_pkg::CFG_ALIGN_BYTES: begin
                    r_align_bytes <= i_cfg_wdata[fbpa_pkg::ALIGN_W-1:0];
                end
                fbpa_pkg::CFG_BLOCKS_IN_USE: begin
                    r_blocks_in_use <= i_cfg_wdata[fbpa_pkg::CNT_W-1:0];
                end
            endcase
        end
    end

    assign pool_blocks = ((MAX_BLOCKS < (1 << fbpa_pkg::CNT_W)) &&
                          (int'(r_blocks_in_use) > MAX_BLOCKS)) ?
                         fbpa_pkg::CNT_W'(MAX_BLOCKS) : r_blocks_in_use;

    fbpa_core #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .o_req_ready     (o_req_ready),
        .i_op            (i_op),
        .i_block_index   (i_block_index),
        .i_request_size  (i_request_size),
        .i_request_align (i_request_align),
        .i_block_bytes   (r_block_bytes),
        .i_align_bytes   (r_align_bytes),
        .i_pool_blocks   (pool_blocks),
        .o_step_valid    (step_valid),
        .i_step_ready    (step_ready),
        .o_step          (step)
    );

    fbpa_result u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step_valid      (step_valid),
        .o_step_ready      (step_ready),
        .i_step            (step),
        .i_base            (r_base),
        .i_block_bytes     (r_block_bytes),
        .i_align_bytes     (r_align_bytes),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_granted_address (o_granted_address),
        .o_used_blocks     (o_used_blocks),
        .o_used_bytes      (o_used_bytes)
    );

endmodule

FILE: tb/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for the fixed block pool allocator: shadow free list and scoreboard.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int POOL_DEPTH  = DEFAULT_MAX_BLOCKS;

    typedef struct {
        t_status            status;
        logic [INDEX_W-1:0] index;
        logic [ADDR_W-1:0]  address;
        logic [CNT_W-1:0]   used;
        logic [BYTES_W-1:0] bytes;
    } t_pool_rsp;

    class pool_shadow;
        logic [ADDR_W-1:0]  base_addr;
        logic [SIZE_W-1:0]  blk_bytes;
        logic [ALIGN_W-1:0] pad_bytes;
        logic [CNT_W-1:0]   pool_limit;
        logic [CNT_W-1:0]   link_next [POOL_DEPTH];
        logic [CNT_W-1:0]   head_ptr;
        logic [CNT_W-1:0]   fresh_ptr;
        logic [CNT_W-1:0]   live_count;
        t_pool_rsp          responses_due [$];
        int                 n_requests;
        int                 n_checked;
        int                 n_grants;
        int                 n_empty;
        int                 n_mismatch;
        int                 n_resize;
        int                 errors;

        function new();
            base_addr  = RST_BASE;
            blk_bytes  = RST_BLOCK_BYTES;
            pad_bytes  = RST_ALIGN_BYTES;
            pool_limit = RST_BLOCKS;
            head_ptr   = '0;
            fresh_ptr  = '0;
            live_count = '0;
        endfunction

        function void set_reg(t_cfg_reg sel, logic [CFG_DATA_W-1:0] value);
            case (sel)
                CFG_BASE:          base_addr  = value[ADDR_W-1:0];
                CFG_BLOCK_BYTES:   blk_bytes  = value[SIZE_W-1:0];
                CFG_ALIGN_BYTES:   pad_bytes  = value[ALIGN_W-1:0];
                CFG_BLOCKS_IN_USE: pool_limit = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_pool_rsp apply_request(t_op op, logic [INDEX_W-1:0] idx,
                                          logic [SIZE_W-1:0] rsize,
                                          logic [ALIGN_W-1:0] ralign);
            t_pool_rsp        r;
            logic [CNT_W-1:0] n;
            logic [CNT_W-1:0] gidx;
            logic [31:0]      stride;
            logic [31:0]      prod;

            r.status  = ST_OK;
            r.index   = '0;
            r.address = '0;
            gidx      = '0;
            n = (pool_limit > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : pool_limit;
            case (op)
                OP_ALLOC: begin
                    if (rsize != blk_bytes || ralign != pad_bytes) begin
                        r.status = ST_MISMATCH;
                    end else if (head_ptr != 0) begin
                        gidx     = head_ptr - CNT_W'(1);
                        head_ptr = link_next[gidx];
                    end else if (fresh_ptr < n) begin
                        gidx      = fresh_ptr;
                        fresh_ptr = fresh_ptr + CNT_W'(1);
                    end else begin
                        r.status = ST_EMPTY;
                    end
                    if (r.status == ST_OK) begin
                        stride    = 32'(blk_bytes) + 32'(pad_bytes);
                        r.index   = gidx[INDEX_W-1:0];
                        r.address = base_addr + 32'(gidx) * stride;
                        if (live_count != CNT_MAX)
                            live_count = live_count + CNT_W'(1);
                    end
                end
                OP_FREE: begin
                    if (CNT_W'(idx) < n) begin
                        link_next[idx] = head_ptr;
                        head_ptr       = CNT_W'(idx) + CNT_W'(1);
                        if (live_count != 0)
                            live_count = live_count - CNT_W'(1);
                    end
                end
                OP_FREE_ALL: begin
                    head_ptr   = '0;
                    fresh_ptr  = '0;
                    live_count = '0;
                end
                default: r.status = ST_RESIZE;
            endcase
            prod    = 32'(live_count) * 32'(blk_bytes);
            r.used  = live_count;
            r.bytes = (prod > 32'(BYTES_SAT)) ? BYTES_SAT : prod[BYTES_W-1:0];
            responses_due.push_back(r);
            n_requests++;
            return r;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                         $time, name, want, want, got, got);
            end
        endfunction

        function void compare_response(logic [1:0] st, logic [INDEX_W-1:0] gi,
                                       logic [ADDR_W-1:0] ga, logic [CNT_W-1:0] ub,
                                       logic [BYTES_W-1:0] by);
            t_pool_rsp want;

            if (responses_due.size() == 0) begin
                errors++;
                $display("%0t: response with no request outstanding, status %0d", $time, st);
                return;
            end
            want = responses_due.pop_front();
            n_checked++;
            check_field("status", 32'(want.status), 32'(st));
            check_field("granted_index", 32'(want.index), 32'(gi));
            check_field("granted_address", want.address, ga);
            check_field("used_blocks", 32'(want.used), 32'(ub));
            check_field("used_bytes", 32'(want.bytes), 32'(by));
            case (want.status)
                ST_OK:       if (want.address != 0 || want.index != 0) n_grants++;
                ST_EMPTY:    n_empty++;
                ST_MISMATCH: n_mismatch++;
                default:     n_resize++;
            endcase
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_req_valid;
    logic                  o_req_ready;
    logic [1:0]            i_op;
    logic [INDEX_W-1:0]    i_block_index;
    logic [SIZE_W-1:0]     i_request_size;
    logic [ALIGN_W-1:0]    i_request_align;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready = 1'b0;
    logic [1:0]            o_status;
    logic [INDEX_W-1:0]    o_granted_index;
    logic [ADDR_W-1:0]     o_granted_address;
    logic [CNT_W-1:0]      o_used_blocks;
    logic [BYTES_W-1:0]    o_used_bytes;

    pool_shadow         shadow;
    logic [INDEX_W-1:0] held [$];
    int                 cycle_count = 0;
    int                 stall_mode  = 0;
    int                 mode_left   = 0;
    int                 settings    = 0;

    fixed_block_pool_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_valid       (i_req_valid),
        .o_req_ready       (o_req_ready),
        .i_op              (i_op),
        .i_block_index     (i_block_index),
        .i_request_size    (i_request_size),
        .i_request_align   (i_request_align),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_granted_address (o_granted_address),
        .o_used_blocks     (o_used_blocks),
        .o_used_bytes      (o_used_bytes)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            shadow.compare_response(o_status, o_granted_index, o_granted_address,
                                    o_used_blocks, o_used_bytes);
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_rsp_ready <= 1'b1;
            1: i_rsp_ready <= 1'($urandom_range(0, 1));
            2: i_rsp_ready <= ($urandom_range(0, 3) == 0);
            default: i_rsp_ready <= cycle_count[2];
        endcase
    end

    task automatic issue(input t_op op, input logic [INDEX_W-1:0] idx,
                         input logic [SIZE_W-1:0] rsize, input logic [ALIGN_W-1:0] ralign);
        t_pool_rsp due;

        i_req_valid     <= 1'b1;
        i_op            <= op;
        i_block_index   <= idx;
        i_request_size  <= rsize;
        i_request_align <= ralign;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        due = shadow.apply_request(op, idx, rsize, ralign);
        if (op == OP_ALLOC && due.status == ST_OK)
            held.push_back(due.index);
        else if (op == OP_FREE_ALL)
            held.delete();
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (shadow.responses_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        shadow.set_reg(sel, value);
    endtask

    task automatic cfg_apply(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] blk,
                             input logic [ALIGN_W-1:0] pad, input logic [CNT_W-1:0] count);
        drain();
        cfg_write(CFG_BASE, base);
        cfg_write(CFG_BLOCK_BYTES, 32'(blk));
        cfg_write(CFG_ALIGN_BYTES, 32'(pad));
        cfg_write(CFG_BLOCKS_IN_USE, 32'(count));
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic run_traffic(input int items);
        int                 left;
        int                 burst;
        int                 gap;
        int                 pick;
        int                 slot;
        logic [INDEX_W-1:0] idx;
        logic [SIZE_W-1:0]  rsize;
        logic [ALIGN_W-1:0] ralign;

        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0) begin
                pick   = $urandom_range(0, 99);
                idx    = INDEX_W'($urandom_range(0, POOL_DEPTH - 1));
                rsize  = SIZE_W'($urandom_range(0, 65535));
                ralign = ALIGN_W'($urandom_range(0, 4096));
                if (pick < 52) begin
                    if ($urandom_range(0, 9) != 0) begin
                        rsize  = shadow.blk_bytes;
                        ralign = shadow.pad_bytes;
                    end
                    issue(OP_ALLOC, idx, rsize, ralign);
                end else if (pick < 88) begin
                    if (held.size() > 0 && $urandom_range(0, 7) != 0) begin
                        slot = $urandom_range(0, held.size() - 1);
                        idx  = held[slot];
                        held.delete(slot);
                    end
                    issue(OP_FREE, idx, rsize, ralign);
                end else if (pick < 94) begin
                    issue(OP_FREE_ALL, idx, rsize, ralign);
                end else begin
                    issue(OP_RESIZE, idx, rsize, ralign);
                end
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        shadow = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_BASE;
        i_cfg_wdata     <= '0;
        i_req_valid     <= 1'b0;
        i_op            <= OP_ALLOC;
        i_block_index   <= '0;
        i_request_size  <= '0;
        i_request_align <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: grants, mismatches, free of a never-granted block, resize, free all
        issue(OP_ALLOC, 10'd1023, 16'd64, 13'd0);
        issue(OP_ALLOC, 10'd0, 16'hFFFF, 13'd0);
        issue(OP_ALLOC, 10'd0, 16'd64, 13'd4096);
        issue(OP_ALLOC, 10'd0, 16'd0, 13'd0);
        issue(OP_FREE, 10'd0, 16'd0, 13'd0);
        issue(OP_FREE, 10'd1023, 16'hFFFF, 13'd4096);
        issue(OP_ALLOC, 10'd0, 16'd64, 13'd0);
        issue(OP_ALLOC, 10'd0, 16'd64, 13'd0);
        issue(OP_ALLOC, 10'd0, 16'd64, 13'd0);
        issue(OP_RESIZE, 10'd1023, 16'hFFFF, 13'd4096);
        issue(OP_FREE_ALL, 10'd0, 16'd64, 13'd0);
        issue(OP_ALLOC, 10'd0, 16'd64, 13'd0);

        // two-block pool: exhaust it, mismatch ahead of empty, out-of-range frees
        cfg_apply(32'hFFFF_FFC0, 16'hFFFF, 13'd4096, 11'd2);
        issue(OP_ALLOC, 10'd0, 16'hFFFF, 13'd4096);
        issue(OP_ALLOC, 10'd0, 16'hFFFF, 13'd4096);
        issue(OP_ALLOC, 10'd0, 16'hFFFF, 13'd4096);
        issue(OP_ALLOC, 10'd0, 16'hFFFE, 13'd4096);
        issue(OP_FREE, 10'd1023, 16'd0, 13'd0);
        issue(OP_FREE, 10'd2, 16'd0, 13'd0);
        issue(OP_FREE, 10'd1, 16'd0, 13'd0);
        issue(OP_ALLOC, 10'd0, 16'hFFFF, 13'd4096);

        // empty pool size
        cfg_apply($urandom, 16'd100, 13'd7, 11'd0);
        issue(OP_ALLOC, 10'd0, 16'd100, 13'd7);
        issue(OP_FREE, 10'd0, 16'd100, 13'd7);

        // repeated free of one block loops the list; the same block is handed out again
        cfg_apply(32'h0000_1000, 16'hFFFF, 13'd0, 11'd1024);
        issue(OP_FREE_ALL, 10'd0, 16'd0, 13'd0);
        issue(OP_FREE, 10'd0, 16'd0, 13'd0);
        issue(OP_FREE, 10'd0, 16'd0, 13'd0);
        repeat (48) issue(OP_ALLOC, INDEX_W'($urandom_range(0, 1023)), 16'hFFFF, 13'd0);
        issue(OP_FREE_ALL, 10'd0, 16'd0, 13'd0);

        cfg_apply(32'hFFFF_F000, 16'hFFFF, 13'd4096, 11'd12);
        run_traffic(120);
        cfg_apply($urandom, 16'd1, 13'd0, 11'd1);
        run_traffic(80);
        cfg_apply($urandom, SIZE_W'($urandom_range(1, 65535)),
                  ALIGN_W'($urandom_range(0, 4096)), 11'd2047);
        run_traffic(150);
        cfg_apply($urandom, 16'd64, 13'd0, 11'd1024);
        run_traffic(150);
        repeat (3) begin
            cfg_apply($urandom, SIZE_W'($urandom_range(1, 65535)),
                      ALIGN_W'($urandom_range(0, 4096)), CNT_W'($urandom_range(2, 40)));
            run_traffic(100);
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests under %0d pool settings, %0d responses checked.",
                 shadow.n_requests, settings + 1, shadow.n_checked);
        $display("Responses: %0d nonzero grants, %0d pool empty, %0d mismatch, %0d resize.",
                 shadow.n_grants, shadow.n_empty, shadow.n_mismatch, shadow.n_resize);
        if (shadow.errors == 0 && shadow.responses_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
